>>> sv/ctt_pkg.sv
// Shared types and constants for the countdown timer table.
package ctt_pkg;

  // Default table sizes
  localparam int TIMER_SLOTS_DEF = 16;
  localparam int FIRED_SLOTS_DEF = 16;

  // Most fired ids handed out by one collect request
  localparam int MAX_RESULTS = 16;
  localparam int KW          = $clog2(MAX_RESULTS + 1);

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Reset value of the tick step register
  localparam logic [15:0] TICK_STEP_RST = 16'd100;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_COLLECT = 2'd3
  } cmd_op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_DUP        = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_FIRED_FULL = 2'd3
  } status_t;

  // One classified request as it travels through the queue
  typedef struct packed {
    cmd_op_t     op;
    logic [15:0] id;
    logic [31:0] delay;
  } cmd_t;

endpackage

>>> sv/countdown_timer_table_unit.sv
// The back end takes a new request only once it has finished the last one; it walks the
// tables one slot per cycle (remove walks max of both tables), pausing a collect while a result
// waits on out_ready; collect hands out each stored id as its own result.
// Reset (synchronous, rst_n low) disarms all timers, empties the fired store and the
// request queue and sets tick_step to 100; table contents are left as they are.
// Top level of the countdown timer table: front queue feeding the table walker.
module countdown_timer_table_unit
  import ctt_pkg::*;
#(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
  parameter int FIRED_SLOTS = FIRED_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_request_id,
  input  logic [31:0] in_delay,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_has_fired_id,
  output logic [15:0] out_fired_id,
  output logic        out_pending,
  output logic        out_last
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Accept and queue requests
  ctt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_request_id (in_request_id),
    .in_delay      (in_delay),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd)
  );

  // Carry out requests against the tables
  ctt_back #(
    .TIMER_SLOTS (TIMER_SLOTS),
    .FIRED_SLOTS (FIRED_SLOTS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .cmd_valid        (cmd_valid),
    .cmd_ready        (cmd_ready),
    .cmd              (cmd),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_has_fired_id (out_has_fired_id),
    .out_fired_id     (out_fired_id),
    .out_pending      (out_pending),
    .out_last         (out_last)
  );

endmodule

>>> sv/ctt_front.sv
// Front end: accepts requests, classifies the command and queues them.
module ctt_front
  import ctt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_request_id,
  input  logic [31:0] in_delay,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          q_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;
  cmd_t          cls;

  // Classify the incoming request
  always_comb begin
    cls.op    = cmd_op_t'(in_command);
    cls.id    = in_request_id;
    cls.delay = in_delay;
  end

  assign in_ready  = (count_r != CW'(QUEUE_DEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold queued requests
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

>>> sv/ctt_back.sv
// Back end: walks the timer and fired tables for each request and emits results.
module ctt_back
  import ctt_pkg::*;
#(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
  parameter int FIRED_SLOTS = FIRED_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_has_fired_id,
  output logic [15:0] out_fired_id,
  output logic        out_pending,
  output logic        out_last
);

  localparam int TA         = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int FA         = (FIRED_SLOTS > 1) ? $clog2(FIRED_SLOTS) : 1;
  localparam int WALK_SLOTS = (TIMER_SLOTS > FIRED_SLOTS) ? TIMER_SLOTS : FIRED_SLOTS;
  localparam int WA         = (WALK_SLOTS > 1) ? $clog2(WALK_SLOTS) : 1;
  localparam int CW         = $clog2(FIRED_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  // Lowest free entry of the fired store
  function automatic logic [FA-1:0] first_free(input logic [FIRED_SLOTS-1:0] v);
    logic [FA-1:0] r;
    r = '0;
    for (int i = FIRED_SLOTS - 1; i >= 0; i--) begin
      if (!v[i]) r = FA'(i);
    end
    return r;
  endfunction

  state_t                 state_r, state_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic [WA-1:0]          idx_r, idx_nxt;
  logic [WA-1:0]          end_r, end_nxt;
  logic                   dup_r, dup_nxt;
  logic                   free_found_r, free_found_nxt;
  logic [TA-1:0]          free_idx_r, free_idx_nxt;
  status_t                stat_r, stat_nxt;
  logic [KW-1:0]          k_r, k_nxt;
  logic [KW-1:0]          n_r, n_nxt;
  logic                   more_r, more_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [TIMER_SLOTS-1:0] tvalid_r, tvalid_nxt;
  logic [FIRED_SLOTS-1:0] fvalid_r, fvalid_nxt;
  logic [15:0]            step_r;

  // Table memories and their registered read data
  logic [15:0] timer_id_mem  [TIMER_SLOTS];
  logic [31:0] timer_rem_mem [TIMER_SLOTS];
  logic [15:0] fired_mem     [FIRED_SLOTS];
  logic [15:0] t_id_q;
  logic [31:0] t_rem_q;
  logic [15:0] f_id_q;

  logic          t_id_we, t_rem_we, f_we;
  logic [TA-1:0] t_wa;
  logic [31:0]   t_rem_wd;
  logic [FA-1:0] f_wa;
  logic [15:0]   f_wd;

  logic          out_valid_r, out_valid_nxt;
  logic          out_load;
  status_t       o_status_r, o_status_nxt;
  logic          o_has_r, o_has_nxt;
  logic [15:0]   o_id_r, o_id_nxt;
  logic          o_pend_r, o_pend_nxt;
  logic          o_last_r, o_last_nxt;

  logic          out_free;
  logic          t_in, f_in;
  logic [TA-1:0] ti;
  logic [FA-1:0] fi;
  logic          advance;
  logic          k_last;

  assign out_free  = !out_valid_r || out_ready;
  assign cmd_ready = (state_r == S_IDLE);
  assign ti        = idx_r[TA-1:0];
  assign fi        = idx_r[FA-1:0];
  assign t_in      = (int'(idx_r) < TIMER_SLOTS);
  assign f_in      = (int'(idx_r) < FIRED_SLOTS);
  assign k_last    = (KW'(k_r + 1'b1) == n_r);

  // Sequencer: take a request, walk the slots, report
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    end_nxt        = end_r;
    dup_nxt        = dup_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    stat_nxt       = stat_r;
    k_nxt          = k_r;
    n_nxt          = n_r;
    more_nxt       = more_r;
    cnt_nxt        = cnt_r;
    tvalid_nxt     = tvalid_r;
    fvalid_nxt     = fvalid_r;
    t_id_we        = 1'b0;
    t_rem_we       = 1'b0;
    t_wa           = ti;
    t_rem_wd       = t_rem_q - {16'd0, step_r};
    f_we           = 1'b0;
    f_wa           = first_free(fvalid_r);
    f_wd           = t_id_q;
    out_load       = 1'b0;
    o_status_nxt   = ST_OK;
    o_has_nxt      = 1'b0;
    o_id_nxt       = '0;
    o_pend_nxt     = (cnt_r != '0);
    o_last_nxt     = 1'b1;
    advance        = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (cmd_valid) begin
          cmd_nxt        = cmd;
          dup_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          free_idx_nxt   = '0;
          stat_nxt       = ST_OK;
          k_nxt          = '0;
          more_nxt       = (int'(cnt_r) > MAX_RESULTS);
          n_nxt          = more_nxt ? KW'(MAX_RESULTS) : KW'(cnt_r);
          unique case (cmd.op)
            CMD_ADD, CMD_TICK: end_nxt = WA'(TIMER_SLOTS - 1);
            CMD_REMOVE:        end_nxt = WA'(WALK_SLOTS - 1);
            CMD_COLLECT:       end_nxt = WA'(FIRED_SLOTS - 1);
            default:           end_nxt = WA'(WALK_SLOTS - 1);
          endcase
          state_nxt = (cmd.op == CMD_COLLECT && cnt_r == '0) ? S_FINISH : S_WALK;
        end
      end

      S_WALK: begin
        unique case (cmd_r.op)
          CMD_ADD: begin
            if (t_in && tvalid_r[ti]) begin
              if (t_id_q == cmd_r.id) dup_nxt = 1'b1;
            end else if (t_in && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_idx_nxt   = ti;
            end
          end
          CMD_REMOVE: begin
            if (t_in && tvalid_r[ti] && t_id_q == cmd_r.id) tvalid_nxt[ti] = 1'b0;
            if (f_in && fvalid_r[fi] && f_id_q == cmd_r.id) begin
              fvalid_nxt[fi] = 1'b0;
              cnt_nxt        = cnt_r - 1'b1;
            end
          end
          CMD_TICK: begin
            if (t_in && tvalid_r[ti]) begin
              if (t_rem_q <= {16'd0, step_r}) begin
                if (cnt_r != CW'(FIRED_SLOTS)) begin
                  f_we             = 1'b1;
                  fvalid_nxt[f_wa] = 1'b1;
                  tvalid_nxt[ti]   = 1'b0;
                  cnt_nxt          = cnt_r + 1'b1;
                end else begin
                  stat_nxt = ST_FIRED_FULL;
                end
              end else begin
                t_rem_we = 1'b1;
              end
            end
          end
          CMD_COLLECT: begin
            if (f_in && fvalid_r[fi]) begin
              if (out_free) begin
                out_load       = 1'b1;
                o_has_nxt      = 1'b1;
                o_id_nxt       = f_id_q;
                o_pend_nxt     = more_r;
                o_last_nxt     = k_last;
                fvalid_nxt[fi] = 1'b0;
                cnt_nxt        = cnt_r - 1'b1;
                k_nxt          = KW'(k_r + 1'b1);
              end else begin
                advance = 1'b0;
              end
            end
          end
          default: ;
        endcase

        // Step to the next slot or wrap up
        if (cmd_r.op == CMD_COLLECT && out_load && k_last) begin
          state_nxt = S_IDLE;
        end else if (advance) begin
          if (idx_r == end_r) begin
            state_nxt = (cmd_r.op == CMD_COLLECT) ? S_IDLE : S_FINISH;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      S_FINISH: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          if (cmd_r.op == CMD_ADD) begin
            if (dup_r) begin
              o_status_nxt = ST_DUP;
            end else if (!free_found_r) begin
              o_status_nxt = ST_TABLE_FULL;
            end else begin
              t_id_we                = 1'b1;
              t_rem_we               = 1'b1;
              t_wa                   = free_idx_r;
              t_rem_wd               = cmd_r.delay;
              tvalid_nxt[free_idx_r] = 1'b1;
            end
          end else begin
            o_status_nxt = stat_r;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_load || (out_valid_r && !out_ready);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      tvalid_r    <= '0;
      fvalid_r    <= '0;
      out_valid_r <= 1'b0;
      step_r      <= TICK_STEP_RST;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      tvalid_r    <= tvalid_nxt;
      fvalid_r    <= fvalid_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      if (cfg_we) step_r <= cfg_wdata;
    end
  end

  // Per-request working registers and result payload
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    end_r        <= end_nxt;
    dup_r        <= dup_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    stat_r       <= stat_nxt;
    k_r          <= k_nxt;
    n_r          <= n_nxt;
    more_r       <= more_nxt;
    if (out_load) begin
      o_status_r <= o_status_nxt;
      o_has_r    <= o_has_nxt;
      o_id_r     <= o_id_nxt;
      o_pend_r   <= o_pend_nxt;
      o_last_r   <= o_last_nxt;
    end
  end

  // Timer table memory: one write, read of the slot visited next
  always_ff @(posedge clk) begin
    if (t_id_we) timer_id_mem[t_wa] <= cmd_r.id;
    if (t_rem_we) timer_rem_mem[t_wa] <= t_rem_wd;
    if (int'(idx_nxt) < TIMER_SLOTS) begin
      t_id_q  <= timer_id_mem[idx_nxt[TA-1:0]];
      t_rem_q <= timer_rem_mem[idx_nxt[TA-1:0]];
    end
  end

  // Fired store memory
  always_ff @(posedge clk) begin
    if (f_we) fired_mem[f_wa] <= f_wd;
    if (int'(idx_nxt) < FIRED_SLOTS) begin
      f_id_q <= fired_mem[idx_nxt[FA-1:0]];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = o_status_r;
  assign out_has_fired_id = o_has_r;
  assign out_fired_id     = o_id_r;
  assign out_pending      = o_pend_r;
  assign out_last         = o_last_r;

endmodule
